@@ sv/clpe_pkg.sv @@
package clpe_pkg;

	// field widths of the item channels
	localparam int ACTION_W = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 6;
	localparam int STATUS_W = 2;

	// default node pool size
	localparam int CAPACITY_DEF = 32;

	// action codes on the request channel
	localparam logic [ACTION_W-1:0] ACT_INS_START = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INS_END = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_INS_KEY = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DEL_START = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DEL_END = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_DEL_KEY = 3'd5;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_NOKEY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// internal operation after remapping of the action
	typedef enum logic [2:0] {
		OP_INS_START = 3'd0,
		OP_INS_END   = 3'd1,
		OP_INS_KEY   = 3'd2,
		OP_DEL_START = 3'd3,
		OP_DEL_END   = 3'd4,
		OP_DEL_KEY   = 3'd5,
		OP_NOP       = 3'd6
	} op_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    latch;
		logic    decide;
		logic    walk_start;
		logic    walk_step;
		logic    wr_a;
		logic    wr_b;
		logic    set_status;
		status_t status;
		logic    load_out;
	} clpe_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic one;
		logic match;
		logic last;
	} clpe_stat_t;

endpackage

@@ sv/clpe_in_if.sv @@
interface clpe_in_if;
	import clpe_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic signed [VALUE_W-1:0]  value;
	logic signed [VALUE_W-1:0]  key;

	modport source (output valid, action, value, key, input ready);
	modport sink (input valid, action, value, key, output ready);

endinterface

@@ sv/clpe_out_if.sv @@
interface clpe_out_if;
	import clpe_pkg::*;

	logic                       valid;
	logic                       ready;
	status_t                    status;
	logic [COUNT_W-1:0]         entry_count;
	logic signed [VALUE_W-1:0]  first_value;
	logic signed [VALUE_W-1:0]  last_value;

	modport source (output valid, status, entry_count, first_value, last_value, input ready);
	modport sink (input valid, status, entry_count, first_value, last_value, output ready);

endinterface

@@ sv/circular_list_node_pool_engine_core.sv @@
// Circular singly linked list of signed 32-bit values kept in a pool of CAPACITY nodes.
// Each request item inserts at the head, at the tail or after the first node equal to key,
// or deletes the head, the tail or the first node equal to key; one result item follows
// with the status, the new count and the head and tail values (zero when empty). Items
// are handled one at a time. Key searches and tail deletes walk the list from the head,
// reading one node a cycle from the value and link memories; an insert after a key
// needs a free node before its walk starts. The result sits in an output register, so
// the next request is taken while an earlier result waits. Node memories need no
// clearing after reset.
module circular_list_node_pool_engine_core #(
	parameter int CAPACITY = clpe_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	clpe_in_if.sink   request,
	clpe_out_if.source result
);
	import clpe_pkg::*;

	clpe_cmd_t  cmd;
	clpe_stat_t stat;

	// sequencing
	clpe_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(request.valid),
		.in_ready(request.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.stat(stat),
		.cmd(cmd)
	);

	// list storage and result registers
	clpe_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.action(request.action),
		.value(request.value),
		.key(request.key),
		.status(result.status),
		.entry_count(result.entry_count),
		.first_value(result.first_value),
		.last_value(result.last_value)
	);

endmodule

@@ sv/clpe_ram.sv @@
module clpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/clpe_ctrl.sv @@
module clpe_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  clpe_pkg::clpe_stat_t   stat,
	output clpe_pkg::clpe_cmd_t    cmd
);
	import clpe_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_WALK   = 6'b000100,
		S_WR_A   = 6'b001000,
		S_WR_B   = 6'b010000,
		S_RESP   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   need_b;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// inserts that link into a non-empty list also go through the second write state
	assign need_b = ((stat.op == OP_INS_START || stat.op == OP_INS_END) && !stat.empty)
		|| (stat.op == OP_INS_KEY);

	// next state and commands
	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				case (stat.op)
					OP_INS_START, OP_INS_END: begin
						if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_FULL;
							state_d = S_RESP;
						end else begin
							state_d = S_WR_A;
						end
					end
					OP_INS_KEY: begin
						if (stat.empty) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_EMPTY;
							state_d = S_RESP;
						end else if (stat.full) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_FULL;
							state_d = S_RESP;
						end else begin
							cmd.walk_start = 1'b1;
							state_d = S_WALK;
						end
					end
					OP_DEL_START: begin
						if (stat.empty) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_EMPTY;
							state_d = S_RESP;
						end else if (stat.one) begin
							state_d = S_WR_A;
						end else begin
							cmd.walk_start = 1'b1;
							state_d = S_WALK;
						end
					end
					OP_DEL_END, OP_DEL_KEY: begin
						if (stat.empty) begin
							cmd.set_status = 1'b1;
							cmd.status = ST_EMPTY;
							state_d = S_RESP;
						end else begin
							cmd.walk_start = 1'b1;
							state_d = S_WALK;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_WALK: begin
				if (stat.match) begin
					state_d = S_WR_A;
				end else if (stat.last) begin
					cmd.set_status = 1'b1;
					cmd.status = ST_NOKEY;
					state_d = S_RESP;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_WR_A: begin
				cmd.wr_a = 1'b1;
				state_d = need_b ? S_WR_B : S_RESP;
			end
			S_WR_B: begin
				cmd.wr_b = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/clpe_dp.sv @@
module clpe_dp #(
	parameter int CAPACITY = clpe_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  clpe_pkg::clpe_cmd_t                 cmd,
	output clpe_pkg::clpe_stat_t                stat,
	input  logic [clpe_pkg::ACTION_W-1:0]       action,
	input  logic signed [clpe_pkg::VALUE_W-1:0] value,
	input  logic signed [clpe_pkg::VALUE_W-1:0] key,
	output clpe_pkg::status_t                   status,
	output logic [clpe_pkg::COUNT_W-1:0]        entry_count,
	output logic signed [clpe_pkg::VALUE_W-1:0] first_value,
	output logic signed [clpe_pkg::VALUE_W-1:0] last_value
);
	import clpe_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef logic [IW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic signed [VALUE_W-1:0] val_t;

	// list control state
	op_t     op_q, op_d;
	status_t status_q;
	idx_t    head_q, tail_q, cur_q, prev_q, n_q;
	cnt_t    count_q, i_q, rtop_q, fresh_q;

	// item and cached values
	val_t    value_q, key_q, hv_q, tv_q, prevval_q;

	// memory ports
	logic    v_we, l_we, s_we;
	idx_t    vl_raddr, l_waddr, l_wdata, l_rdata, v_waddr;
	idx_t    s_waddr, s_wdata, s_raddr, s_rdata;
	val_t    v_wdata, v_rdata;

	idx_t    alloc;
	logic    is_del;
	logic    walk_hit;

	// node values, node links and the stack of recycled nodes
	clpe_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_vals (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(vl_raddr), .rdata(v_rdata)
	);

	clpe_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_links (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(vl_raddr), .rdata(l_rdata)
	);

	clpe_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	// recycled nodes first, then never-used nodes from the top down
	assign s_raddr = idx_t'(rtop_q - cnt_t'(1));
	assign alloc = (rtop_q != '0) ? s_rdata : idx_t'(fresh_q - cnt_t'(1));

	// status toward the controller
	assign stat.op = op_q;
	assign stat.empty = (count_q == '0);
	assign stat.full = (count_q == cnt_t'(CAPACITY));
	assign stat.one = (count_q == cnt_t'(1));
	assign stat.last = ((CW+1)'(i_q) + (CW+1)'(1)) == (CW+1)'(count_q);
	assign stat.match = walk_hit;

	// per-operation walk stop condition on the node just read
	always_comb begin
		case (op_q)
			OP_INS_KEY:   walk_hit = (v_rdata == key_q);
			OP_DEL_END:   walk_hit = (l_rdata == tail_q);
			OP_DEL_KEY:   walk_hit = (i_q != '0) && (v_rdata == key_q);
			OP_DEL_START: walk_hit = (i_q != '0);
			default:      walk_hit = 1'b0;
		endcase
	end

	// action to operation, head-match delete and single-node delete fold into delete start
	always_comb begin
		case (action)
			ACT_INS_START: op_d = OP_INS_START;
			ACT_INS_END:   op_d = OP_INS_END;
			ACT_INS_KEY:   op_d = OP_INS_KEY;
			ACT_DEL_START: op_d = OP_DEL_START;
			ACT_DEL_END:   op_d = (count_q == cnt_t'(1)) ? OP_DEL_START : OP_DEL_END;
			ACT_DEL_KEY:   op_d = (count_q != '0 && hv_q == key) ? OP_DEL_START : OP_DEL_KEY;
			default:       op_d = OP_NOP;
		endcase
	end

	assign is_del = (op_q == OP_DEL_START) || (op_q == OP_DEL_END) || (op_q == OP_DEL_KEY);

	// shared read address of the value and link memories
	always_comb begin
		if (cmd.walk_step) begin
			vl_raddr = l_rdata;
		end else if (cmd.walk_start) begin
			vl_raddr = head_q;
		end else begin
			vl_raddr = cur_q;
		end
	end

	// value write: new node on insert
	assign v_we = cmd.wr_a && (op_q == OP_INS_START || op_q == OP_INS_END
		|| op_q == OP_INS_KEY);
	assign v_waddr = n_q;
	assign v_wdata = value_q;

	// link writes
	always_comb begin
		l_we = 1'b0;
		l_waddr = n_q;
		l_wdata = head_q;
		if (cmd.wr_a) begin
			case (op_q)
				OP_INS_START, OP_INS_END: begin
					l_we = 1'b1;
					l_waddr = n_q;
					l_wdata = (count_q == '0) ? n_q : head_q;
				end
				OP_INS_KEY: begin
					l_we = 1'b1;
					l_waddr = n_q;
					l_wdata = l_rdata;
				end
				OP_DEL_START: begin
					l_we = (count_q != cnt_t'(1));
					l_waddr = tail_q;
					l_wdata = cur_q;
				end
				OP_DEL_END: begin
					l_we = 1'b1;
					l_waddr = cur_q;
					l_wdata = head_q;
				end
				OP_DEL_KEY: begin
					l_we = 1'b1;
					l_waddr = prev_q;
					l_wdata = l_rdata;
				end
				default: begin
					l_we = 1'b0;
				end
			endcase
		end else if (cmd.wr_b) begin
			case (op_q)
				OP_INS_START, OP_INS_END: begin
					l_we = 1'b1;
					l_waddr = tail_q;
					l_wdata = n_q;
				end
				OP_INS_KEY: begin
					l_we = 1'b1;
					l_waddr = cur_q;
					l_wdata = n_q;
				end
				default: begin
					l_we = 1'b0;
				end
			endcase
		end
	end

	// push of the freed node
	assign s_we = cmd.wr_a && is_del;
	assign s_waddr = rtop_q[IW-1:0];
	always_comb begin
		case (op_q)
			OP_DEL_START: s_wdata = (count_q == cnt_t'(1)) ? head_q : prev_q;
			OP_DEL_END:   s_wdata = tail_q;
			default:      s_wdata = cur_q;
		endcase
	end

	// list control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_NOP;
			status_q <= ST_DONE;
			head_q <= '0;
			tail_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			n_q <= '0;
			count_q <= '0;
			i_q <= '0;
			rtop_q <= '0;
			fresh_q <= cnt_t'(CAPACITY);
		end else begin
			if (cmd.latch) begin
				op_q <= op_d;
				status_q <= ST_DONE;
			end
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.decide) begin
				n_q <= alloc;
			end
			if (cmd.walk_start) begin
				cur_q <= head_q;
				i_q <= '0;
			end
			if (cmd.walk_step) begin
				prev_q <= cur_q;
				cur_q <= l_rdata;
				i_q <= i_q + cnt_t'(1);
			end
			if (cmd.wr_a) begin
				// pop on insert
				if (op_q == OP_INS_START || op_q == OP_INS_END || op_q == OP_INS_KEY) begin
					if (rtop_q != '0) begin
						rtop_q <= rtop_q - cnt_t'(1);
					end else begin
						fresh_q <= fresh_q - cnt_t'(1);
					end
				end
				if (is_del) begin
					rtop_q <= rtop_q + cnt_t'(1);
				end
				case (op_q)
					OP_INS_START, OP_INS_END: begin
						if (count_q == '0) begin
							head_q <= n_q;
							tail_q <= n_q;
							count_q <= cnt_t'(1);
						end
					end
					OP_DEL_START: begin
						if (count_q == cnt_t'(1)) begin
							head_q <= '0;
							tail_q <= '0;
							count_q <= '0;
						end else begin
							head_q <= cur_q;
							count_q <= count_q - cnt_t'(1);
						end
					end
					OP_DEL_END: begin
						tail_q <= cur_q;
						count_q <= count_q - cnt_t'(1);
					end
					OP_DEL_KEY: begin
						if (cur_q == tail_q) begin
							tail_q <= prev_q;
						end
						count_q <= count_q - cnt_t'(1);
					end
					default: begin
					end
				endcase
			end
			if (cmd.wr_b) begin
				case (op_q)
					OP_INS_START: begin
						head_q <= n_q;
						count_q <= count_q + cnt_t'(1);
					end
					OP_INS_END: begin
						tail_q <= n_q;
						count_q <= count_q + cnt_t'(1);
					end
					OP_INS_KEY: begin
						if (cur_q == tail_q) begin
							tail_q <= n_q;
						end
						count_q <= count_q + cnt_t'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// item, head and tail values, result payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			value_q <= value;
			key_q <= key;
		end
		if (cmd.walk_step) begin
			prevval_q <= v_rdata;
		end
		if (cmd.wr_a) begin
			case (op_q)
				OP_INS_START, OP_INS_END: begin
					if (count_q == '0) begin
						hv_q <= value_q;
						tv_q <= value_q;
					end
				end
				OP_DEL_START: begin
					if (count_q != cnt_t'(1)) begin
						hv_q <= v_rdata;
					end
				end
				OP_DEL_END: begin
					tv_q <= v_rdata;
				end
				OP_DEL_KEY: begin
					if (cur_q == tail_q) begin
						tv_q <= prevval_q;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.wr_b) begin
			case (op_q)
				OP_INS_START: hv_q <= value_q;
				OP_INS_END:   tv_q <= value_q;
				OP_INS_KEY: begin
					if (cur_q == tail_q) begin
						tv_q <= value_q;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.load_out) begin
			status <= status_q;
			entry_count <= COUNT_W'(count_q);
			first_value <= (count_q == '0) ? '0 : hv_q;
			last_value <= (count_q == '0) ? '0 : tv_q;
		end
	end

endmodule
